// ===== rtl/bpeq_pkg.sv =====
// Package: beat types, register map and reset values for the button press event qualifier.
`timescale 1ns / 1ps
package bpeq_pkg;

	typedef struct packed {
		logic        level_in;
		logic [31:0] now_ms;
	} bpeq_in_t;

	typedef struct packed {
		logic       press_event;
		logic [7:0] click_count;
		logic       long_flag;
		logic       repeat_flag;
		logic       level_now;
	} bpeq_out_t;

	localparam int unsigned ADDR_W = 4;
	localparam int unsigned DATA_W = 32;

	typedef enum logic [1:0] {
		REG_ENABLED      = 2'd0,
		REG_MULTI_WINDOW = 2'd1,
		REG_LONG_PRESS   = 2'd2,
		REG_REPEAT       = 2'd3
	} bpeq_reg_t;

	localparam logic        RST_ENABLED      = 1'b1;
	localparam logic [15:0] RST_MULTI_WINDOW = 16'd500;
	localparam logic [15:0] RST_LONG_PRESS   = 16'd1000;
	localparam logic [15:0] RST_REPEAT       = 16'd100;

endpackage

// ===== rtl/button_press_event_qualifier_top.sv =====
// Top level: button press event qualifier with long press, repeat and multi-click count.
`timescale 1ns / 1ps
// One poll beat (button level, millisecond timestamp) is taken each clock cycle while
// poll_stall is low and yields one result beat: the poll is registered, the button state
// update and event decision are combinational, and the result sits in an output register.
// Throughput is one poll per cycle unless result_stall holds it, set by the state register
// loop. A stalled result holds the output register; one further poll is still taken into
// the input register before poll_stall rises. Register writes are meant for idle time.
module button_press_event_qualifier_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          poll_valid,
	output logic                          poll_stall,
	input  bpeq_pkg::bpeq_in_t            poll_data,
	output logic                          result_valid,
	input  logic                          result_stall,
	output bpeq_pkg::bpeq_out_t           result_data,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [bpeq_pkg::ADDR_W-1:0]   paddr,
	input  logic [bpeq_pkg::DATA_W-1:0]   pwdata,
	output logic [bpeq_pkg::DATA_W-1:0]   prdata,
	output logic                          pready
);
	import bpeq_pkg::*;

	// configuration
	logic        enabled_q;
	logic [15:0] multi_window_q;
	logic [15:0] long_press_q;
	logic [15:0] repeat_q;
	bpeq_reg_t   reg_sel;
	logic        cfg_wr;

	// pipeline
	logic      valid_s1;
	bpeq_in_t  poll_s1;
	logic      advance;
	logic      result_valid_q;
	bpeq_out_t result_q;

	// button state
	logic        last_level_q;
	logic [31:0] press_start_q;
	logic [31:0] first_press_q;
	logic [7:0]  clicks_q;
	logic        long_held_q;
	logic        repeating_q;

	logic        last_level_d;
	logic [31:0] press_start_d;
	logic [31:0] first_press_d;
	logic [7:0]  clicks_d;
	logic        long_held_d;
	logic        repeating_d;
	logic        event_d;

	logic [31:0] window_age;
	logic [31:0] hold_age;
	logic [7:0]  clicks_base;
	logic [7:0]  clicks_inc;

	assign pready  = 1'b1;
	assign reg_sel = bpeq_reg_t'(paddr[ADDR_W-1:2]);
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		prdata = '0;
		unique case (reg_sel)
			REG_ENABLED:      prdata = {{(DATA_W-1){1'b0}}, enabled_q};
			REG_MULTI_WINDOW: prdata = {{(DATA_W-16){1'b0}}, multi_window_q};
			REG_LONG_PRESS:   prdata = {{(DATA_W-16){1'b0}}, long_press_q};
			REG_REPEAT:       prdata = {{(DATA_W-16){1'b0}}, repeat_q};
			default:          prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enabled_q      <= RST_ENABLED;
			multi_window_q <= RST_MULTI_WINDOW;
			long_press_q   <= RST_LONG_PRESS;
			repeat_q       <= RST_REPEAT;
		end else if (cfg_wr) begin
			unique case (reg_sel)
				REG_ENABLED:      enabled_q      <= pwdata[0];
				REG_MULTI_WINDOW: multi_window_q <= pwdata[15:0];
				REG_LONG_PRESS:   long_press_q   <= pwdata[15:0];
				REG_REPEAT:       repeat_q       <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// handshake
	assign advance      = valid_s1 && (!result_valid_q || !result_stall);
	assign poll_stall   = valid_s1 && !advance;
	assign result_valid = result_valid_q;
	assign result_data  = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1       <= 1'b0;
			result_valid_q <= 1'b0;
		end else begin
			if (!poll_stall)
				valid_s1 <= poll_valid;
			if (advance)
				result_valid_q <= 1'b1;
			else if (!result_stall)
				result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!poll_stall && poll_valid)
			poll_s1 <= poll_data;
	end

	// state update for the poll in s1
	assign window_age  = poll_s1.now_ms - first_press_q;
	assign hold_age    = poll_s1.now_ms - press_start_q;
	assign clicks_base = (window_age > {16'd0, multi_window_q}) ? 8'd0 : clicks_q;
	assign clicks_inc  = clicks_base + 8'd1;

	always_comb begin
		last_level_d  = last_level_q;
		press_start_d = press_start_q;
		first_press_d = first_press_q;
		clicks_d      = clicks_q;
		long_held_d   = long_held_q;
		repeating_d   = repeating_q;
		event_d       = 1'b0;
		if (enabled_q) begin
			last_level_d = poll_s1.level_in;
			clicks_d     = clicks_base;
			if (poll_s1.level_in) begin
				press_start_d = '0;
				long_held_d   = 1'b0;
				repeating_d   = 1'b0;
			end else if (last_level_q) begin
				press_start_d = poll_s1.now_ms;
				clicks_d      = clicks_inc;
				if (clicks_inc == 8'd1)
					first_press_d = poll_s1.now_ms;
				event_d = 1'b1;
			end else if (!long_held_q) begin
				if (hold_age > {16'd0, long_press_q}) begin
					long_held_d   = 1'b1;
					press_start_d = poll_s1.now_ms;
					event_d       = 1'b1;
				end
			end else if (hold_age > {16'd0, repeat_q}) begin
				repeating_d   = 1'b1;
				press_start_d = poll_s1.now_ms;
				event_d       = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q  <= 1'b1;
			press_start_q <= '0;
			first_press_q <= '0;
			clicks_q      <= '0;
			long_held_q   <= 1'b0;
			repeating_q   <= 1'b0;
		end else if (advance) begin
			last_level_q  <= last_level_d;
			press_start_q <= press_start_d;
			first_press_q <= first_press_d;
			clicks_q      <= clicks_d;
			long_held_q   <= long_held_d;
			repeating_q   <= repeating_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_q.press_event <= event_d;
			result_q.click_count <= clicks_d;
			result_q.long_flag   <= long_held_d;
			result_q.repeat_flag <= repeating_d;
			result_q.level_now   <= last_level_d;
		end
	end

	// checks
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		poll_stall |-> valid_s1)
		else $error("poll stalled with empty input register");

	a_no_event_released: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> !(result_data.press_event && result_data.level_now))
		else $error("event reported on a released level");

	a_release_clears_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.level_now |->
			!result_data.long_flag && !result_data.repeat_flag)
		else $error("flags set while released");

	a_repeat_needs_long: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.repeat_flag |-> result_data.long_flag)
		else $error("repeat without long press");

	a_new_press_event: assert property (@(posedge clk) disable iff (!arst_n)
		advance && enabled_q && !poll_s1.level_in && last_level_q |=>
			result_valid && result_data.press_event)
		else $error("new press did not raise an event");

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the button press event qualifier: random and directed polls checked against a predictor.
`timescale 1ns / 1ps
module tb_top;
	import bpeq_pkg::*;

	localparam int CYCLE_LIMIT = 300000;

	logic clk;
	logic arst_n = 1'b0;
	logic poll_valid = 1'b0;
	logic poll_stall;
	bpeq_in_t poll_data = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	bpeq_out_t result_data;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [DATA_W-1:0] pwdata = '0;
	logic [DATA_W-1:0] prdata;
	logic pready;

	button_press_event_qualifier_top i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.poll_valid(poll_valid),
		.poll_stall(poll_stall),
		.poll_data(poll_data),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.result_data(result_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// configuration copy
	logic        cfg_enabled;
	logic [15:0] cfg_multi_window;
	logic [15:0] cfg_long_press;
	logic [15:0] cfg_repeat;

	// button state copy
	logic        btn_level;
	logic [31:0] hold_start_ms;
	logic [31:0] group_start_ms;
	logic [7:0]  click_tally;
	logic        long_seen;
	logic        repeat_seen;

	bpeq_in_t  pending_polls[$];
	bpeq_out_t expected_results[$];

	bit idle_on = 1'b1;
	int mismatch_count = 0;
	int results_seen = 0;
	int stall_hold_left = 0;
	bit stall_hold_done = 1'b0;
	int cycle_count = 0;

	logic        stim_level = 1'b1;
	logic [31:0] stim_now = '0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	function automatic bpeq_out_t qualify_poll(bpeq_in_t poll);
		bpeq_out_t res;
		logic prev;
		logic [31:0] since;
		res = '0;
		if (cfg_enabled) begin
			prev = btn_level;
			btn_level = poll.level_in;
			since = poll.now_ms - group_start_ms;
			if (since > {16'h0, cfg_multi_window})
				click_tally = '0;
			since = poll.now_ms - hold_start_ms;
			if (poll.level_in) begin
				hold_start_ms = '0;
				long_seen = 1'b0;
				repeat_seen = 1'b0;
			end else if (prev != poll.level_in) begin
				hold_start_ms = poll.now_ms;
				click_tally = click_tally + 8'd1;
				if (click_tally == 8'd1)
					group_start_ms = poll.now_ms;
				res.press_event = 1'b1;
			end else if (!long_seen) begin
				if (since > {16'h0, cfg_long_press}) begin
					long_seen = 1'b1;
					hold_start_ms = poll.now_ms;
					res.press_event = 1'b1;
				end
			end else if (since > {16'h0, cfg_repeat}) begin
				repeat_seen = 1'b1;
				hold_start_ms = poll.now_ms;
				res.press_event = 1'b1;
			end
		end
		res.click_count = click_tally;
		res.long_flag = long_seen;
		res.repeat_flag = repeat_seen;
		res.level_now = btn_level;
		return res;
	endfunction

	// poll driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (poll_valid && !poll_stall)
				expected_results.push_back(qualify_poll(poll_data));
			if (!poll_valid || !poll_stall) begin
				if (pending_polls.size() != 0 && !(idle_on && $urandom_range(0, 99) < 35)) begin
					poll_valid <= 1'b1;
					poll_data <= pending_polls.pop_front();
				end else begin
					poll_valid <= 1'b0;
				end
			end
		end
	end

	function automatic void check_field(string name, int exp_val, int act_val);
		if (exp_val != act_val) begin
			$error("%s: expected %0d, got %0d", name, exp_val, act_val);
			mismatch_count++;
		end
	endfunction

	// result monitor
	always @(posedge clk) begin
		bpeq_out_t exp_res;
		if (arst_n) begin
			if (result_valid && !result_stall) begin
				results_seen++;
				if (expected_results.size() == 0) begin
					$error("result beat with no poll outstanding");
					mismatch_count++;
				end else begin
					exp_res = expected_results.pop_front();
					check_field("press_event", int'(exp_res.press_event),
						int'(result_data.press_event));
					check_field("click_count", int'(exp_res.click_count),
						int'(result_data.click_count));
					check_field("long_flag", int'(exp_res.long_flag),
						int'(result_data.long_flag));
					check_field("repeat_flag", int'(exp_res.repeat_flag),
						int'(result_data.repeat_flag));
					check_field("level_now", int'(exp_res.level_now),
						int'(result_data.level_now));
				end
			end
			if (results_seen == 500 && !stall_hold_done) begin
				stall_hold_left = 300;
				stall_hold_done = 1'b1;
			end
			if (stall_hold_left > 0) begin
				stall_hold_left--;
				result_stall <= 1'b1;
			end else begin
				result_stall <= idle_on && ($urandom_range(0, 99) < 35);
			end
		end
	end

	task automatic write_reg(bpeq_reg_t reg_idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {reg_idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (reg_idx)
			REG_ENABLED:      cfg_enabled = value[0];
			REG_MULTI_WINDOW: cfg_multi_window = value[15:0];
			REG_LONG_PRESS:   cfg_long_press = value[15:0];
			REG_REPEAT:       cfg_repeat = value[15:0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	task automatic apply_config(logic en, logic [15:0] win, logic [15:0] lp, logic [15:0] rp);
		write_reg(REG_MULTI_WINDOW, {16'h0, win});
		write_reg(REG_LONG_PRESS, {16'h0, lp});
		write_reg(REG_REPEAT, {16'h0, rp});
		write_reg(REG_ENABLED, {31'h0, en});
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_polls.size() != 0 || poll_valid || expected_results.size() != 0);
		repeat (4) @(negedge clk);
	endtask

	function automatic void add_poll(logic level, logic [31:0] now);
		bpeq_in_t p;
		p.level_in = level;
		p.now_ms = now;
		pending_polls.push_back(p);
	endfunction

	// mostly plausible press/hold/release activity, with steps near the thresholds
	task automatic queue_button_activity(int count);
		int step;
		int pick;
		int base;
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 8) begin
				stim_level = 1'($urandom_range(0, 1));
				stim_now = $urandom;
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3: step = $urandom_range(0, 30);
					4, 5, 6: begin
						pick = $urandom_range(0, 2);
						base = (pick == 0) ? int'(cfg_multi_window) :
							(pick == 1) ? int'(cfg_long_press) : int'(cfg_repeat);
						step = base + int'($urandom_range(0, 4)) - 2;
						if (step < 0)
							step = 0;
					end
					7: step = $urandom_range(0, 3000);
					8: step = $urandom_range(0, 70000);
					default: step = 0;
				endcase
				stim_now += 32'(step);
				if (stim_level)
					stim_level = ($urandom_range(0, 99) >= 50);
				else
					stim_level = ($urandom_range(0, 99) < 20);
			end
			add_poll(stim_level, stim_now);
		end
	endtask

	// fast clicking inside one wide window, enough presses to wrap the count
	task automatic queue_click_burst(int count);
		stim_now += 32'd70000;
		stim_level = 1'b1;
		add_poll(stim_level, stim_now);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 95)
				stim_level = ~stim_level;
			stim_now += $urandom_range(0, 30);
			add_poll(stim_level, stim_now);
		end
	endtask

	initial begin
		cfg_enabled = RST_ENABLED;
		cfg_multi_window = RST_MULTI_WINDOW;
		cfg_long_press = RST_LONG_PRESS;
		cfg_repeat = RST_REPEAT;
		btn_level = 1'b1;
		hold_start_ms = '0;
		group_start_ms = '0;
		click_tally = '0;
		long_seen = 1'b0;
		repeat_seen = 1'b0;

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: threshold edges, long press, repeat, window expiry, timestamp wrap
		add_poll(1'b1, 32'd0);
		add_poll(1'b0, 32'd10);
		add_poll(1'b0, 32'd1010);
		add_poll(1'b0, 32'd1011);
		add_poll(1'b0, 32'd1111);
		add_poll(1'b0, 32'd1112);
		add_poll(1'b0, 32'd1213);
		add_poll(1'b1, 32'd1300);
		add_poll(1'b0, 32'd1400);
		add_poll(1'b1, 32'd1450);
		add_poll(1'b0, 32'd1500);
		add_poll(1'b1, 32'd1550);
		add_poll(1'b0, 32'd1900);
		add_poll(1'b1, 32'd1901);
		add_poll(1'b0, 32'hFFFF_FF00);
		add_poll(1'b0, 32'h0000_0100);
		add_poll(1'b0, 32'hFFFF_FFFF);
		add_poll(1'b1, 32'hFFFF_FFFF);
		add_poll(1'b0, 32'h0000_0000);
		add_poll(1'b0, 32'h8000_0000);
		add_poll(1'b1, 32'h7FFF_FFFF);
		stim_now = 32'h7FFF_FFFF;
		wait_drained();

		apply_config(1'b1, 16'd500, 16'd1000, 16'd100);
		queue_button_activity(120);
		wait_drained();

		apply_config(1'b1, 16'd0, 16'd0, 16'd0);
		queue_button_activity(100);
		wait_drained();

		apply_config(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		queue_button_activity(80);
		wait_drained();

		queue_click_burst(600);
		wait_drained();

		apply_config(1'b0, 16'($urandom), 16'($urandom), 16'($urandom));
		queue_button_activity(40);
		wait_drained();

		idle_on = 1'b0;
		apply_config(1'b1, 16'($urandom_range(20, 800)), 16'($urandom_range(50, 1500)),
			16'($urandom_range(0, 200)));
		queue_button_activity(130);
		wait_drained();
		idle_on = 1'b1;

		repeat (10) @(negedge clk);
		mismatch_count += expected_results.size();
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/bpeq_pkg.sv
rtl/button_press_event_qualifier_top.sv
dv/tb_top.sv
